[sv/flag_frame_unescape_xor_check_macros.svh]
// Assertion macros for the flag frame unescape block.
// Used by the top level only; needs a clock and a reset in the scope of use.
`ifndef FLAG_FRAME_UNESCAPE_XOR_CHECK_MACROS_SVH
`define FLAG_FRAME_UNESCAPE_XOR_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFUX_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffux assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFUX_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffux assertion failed");

`endif

[sv/ffux_pkg.sv]
// Shared constants and types of the flag frame unescape block.
// Used by ffux_step and by the top level; depends on nothing.
package ffux_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;
   localparam logic [7:0] ESC_ESC   = 8'h5D;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FLAG  = 3'd1;
   localparam logic [2:0] ST_SHORT = 3'd2;
   localparam logic [2:0] ST_CSUM  = 3'd3;
   localparam logic [2:0] ST_ESC   = 3'd4;

   localparam logic [1:0] POS_START = 2'd0;
   localparam logic [1:0] POS_BODY  = 2'd1;

   typedef struct packed {
      logic [1:0] byte_position;
      logic       start_flag_ok;
      logic       escape_pending;
      logic       escape_fault;
      logic       held_valid;
      logic [7:0] held_byte;
      logic [7:0] running_xor;
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic       is_status;
      logic [2:0] status_code;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      byte_position:  POS_START,
      start_flag_ok:  1'b0,
      escape_pending: 1'b0,
      escape_fault:   1'b0,
      held_valid:     1'b0,
      held_byte:      8'h00,
      running_xor:    8'h00
   };

endpackage

[sv/ffux_step.sv]
// Per-byte deframing logic: next frame state and the result for one byte.
// Purely combinational; uses the types and constants of ffux_pkg.
module ffux_step (
   input  ffux_pkg::state_type  cur_state,
   input  logic [7:0]           rx_byte,
   input  logic                 frame_end,
   output ffux_pkg::state_type  nxt_state,
   output ffux_pkg::result_type result
);

   logic [7:0] dec;
   logic       have_dec;
   logic [2:0] end_code;

   // Decode of a body byte, taking a pending escape into account.
   always_comb begin
      dec      = rx_byte;
      have_dec = 1'b1;
      if (cur_state.escape_pending) begin
         if (rx_byte == ffux_pkg::ESC_FLAG) begin
            dec = ffux_pkg::FLAG_BYTE;
         end else if (rx_byte == ffux_pkg::ESC_ESC) begin
            dec = ffux_pkg::ESC_BYTE;
         end
      end else if (rx_byte == ffux_pkg::ESC_BYTE) begin
         have_dec = 1'b0;
      end
   end

   // Closing status, in order of priority.
   always_comb begin
      if (!cur_state.start_flag_ok || rx_byte != ffux_pkg::FLAG_BYTE) begin
         end_code = ffux_pkg::ST_FLAG;
      end else if (cur_state.escape_fault || cur_state.escape_pending) begin
         end_code = ffux_pkg::ST_ESC;
      end else if (!cur_state.held_valid) begin
         end_code = ffux_pkg::ST_SHORT;
      end else if (cur_state.held_byte != cur_state.running_xor) begin
         end_code = ffux_pkg::ST_CSUM;
      end else begin
         end_code = ffux_pkg::ST_OK;
      end
   end

   always_comb begin
      nxt_state          = cur_state;
      result.valid       = 1'b0;
      result.out_byte    = 8'h00;
      result.is_status   = 1'b0;
      result.status_code = ffux_pkg::ST_OK;
      if (cur_state.byte_position == ffux_pkg::POS_START) begin
         if (frame_end) begin
            nxt_state          = ffux_pkg::STATE_CLEAR;
            result.valid       = 1'b1;
            result.is_status   = 1'b1;
            result.status_code = (rx_byte == ffux_pkg::FLAG_BYTE) ?
                                 ffux_pkg::ST_SHORT : ffux_pkg::ST_FLAG;
         end else begin
            nxt_state               = ffux_pkg::STATE_CLEAR;
            nxt_state.start_flag_ok = (rx_byte == ffux_pkg::FLAG_BYTE);
            nxt_state.byte_position = ffux_pkg::POS_BODY;
         end
      end else if (frame_end) begin
         nxt_state          = ffux_pkg::STATE_CLEAR;
         result.valid       = 1'b1;
         result.is_status   = 1'b1;
         result.status_code = end_code;
      end else begin
         if (cur_state.escape_pending) begin
            nxt_state.escape_pending = 1'b0;
            if (rx_byte != ffux_pkg::ESC_FLAG && rx_byte != ffux_pkg::ESC_ESC) begin
               nxt_state.escape_fault = 1'b1;
            end
         end else if (rx_byte == ffux_pkg::ESC_BYTE) begin
            nxt_state.escape_pending = 1'b1;
         end
         if (have_dec) begin
            // The held byte is released and folded into the checksum only
            // once a newer decoded byte replaces it.
            if (cur_state.held_valid) begin
               nxt_state.running_xor = cur_state.running_xor ^ cur_state.held_byte;
               if (cur_state.start_flag_ok) begin
                  result.valid    = 1'b1;
                  result.out_byte = cur_state.held_byte;
               end
            end
            nxt_state.held_byte  = dec;
            nxt_state.held_valid = 1'b1;
         end
      end
   end

endmodule

[sv/flag_frame_unescape_xor_check.sv]
// Channel   Dir  Item contents
// req_      in   tdata[7:0] received byte, tlast frame end
// rsp_      out  tdata[7:0] decoded byte, tlast status, tuser[2:0] status code
//
// One byte is taken per cycle while req_tready is high; its result, if any, shows in the output
// register on the next cycle. The frame state register and that output
// register are the only storage, with ffux_step between them.
// A stalled result blocks the input only while rsp_tready is low.
// Synchronous active-high reset clears the frame state and the output valid.
//
// Top level of the flag frame unescape block; uses ffux_pkg and ffux_step.
// Assertions come from flag_frame_unescape_xor_check_macros.svh.
`include "flag_frame_unescape_xor_check_macros.svh"

module flag_frame_unescape_xor_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,   // is_status
   output logic [2:0] rsp_tuser    // [2:0] status_code
);

   ffux_pkg::state_type  state_ff;
   ffux_pkg::state_type  state_in;
   ffux_pkg::state_type  step_state;
   ffux_pkg::result_type step_result;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic [2:0] rsp_code_ff;
   logic       accept;

   ffux_step u_step (
      .cur_state (state_ff),
      .rx_byte   (req_tdata),
      .frame_end (req_tlast),
      .nxt_state (step_state),
      .result    (step_result)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign state_in   = accept ? step_state : state_ff;

   always_comb begin
      if (accept && step_result.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffux_pkg::STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.valid) begin
         rsp_byte_ff <= step_result.out_byte;
         rsp_last_ff <= step_result.is_status;
         rsp_code_ff <= step_result.status_code;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_code_ff;

   `FFUX_ASSERT_NEXT(a_end_gives_status, accept && req_tlast, rsp_tvalid && rsp_tlast)
   `FFUX_ASSERT_SAME(a_status_has_no_data, rsp_tvalid && rsp_tlast, rsp_tdata == 8'h00)
   `FFUX_ASSERT_SAME(a_data_has_no_code, rsp_tvalid && !rsp_tlast, rsp_tuser == ffux_pkg::ST_OK)
   `FFUX_ASSERT_SAME(a_idle_state_clear, state_ff.byte_position == ffux_pkg::POS_START, !state_ff.held_valid && !state_ff.escape_pending && state_ff.running_xor == 8'h00)

endmodule
